// ===== rtl/fqss_pkg.sv =====
// ============================================================================
// fqss_pkg
// Shared types and constants of the FIFO queue with sort and search.
// ============================================================================
package fqss_pkg;

  // Queue geometry. DEPTH must be a power of two so ring positions wrap on AW bits.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = 7;
  localparam int unsigned DW    = 32;

  typedef enum logic [2:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_SORT   = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_MISS  = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    DSEL_ZERO  = 2'd0,
    DSEL_RDATA = 2'd1,
    DSEL_KEY   = 2'd2,
    DSEL_ONES  = 2'd3
  } dsel_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_FRONT,
    S_SIMPLE,
    S_SEARCH,
    S_SRCH_CMP,
    S_SRCH_DONE,
    S_SORT_PASS,
    S_SORT_LOAD,
    S_SORT_READ,
    S_SORT_STEP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  accept;
    logic  rd_idx;
    logic  push_wr;
    logic  pop;
    logic  clear;
    logic  srch_next;
    logic  srch_hit;
    logic  sort_load;
    logic  sort_step;
    logic  sort_flush;
    logic  out_load;
    dsel_e out_dsel;
    stat_e out_stat;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_end;
    logic sort_done;
    logic match;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/fqss_ram.sv =====
// ============================================================================
// fqss_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module fqss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fqss_ctrl.sv =====
// ============================================================================
// fqss_ctrl
// Request sequencer: decodes each request and steps the datapath through it.
// ============================================================================
module fqss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [2:0]       req_type_i,
  output logic             in_ready_o,
  input  fqss_pkg::sts_t   sts_i,
  output fqss_pkg::cmd_t   cmd_o
);

  fqss_pkg::state_e state_q, state_d;
  logic [2:0]       kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fqss_pkg::S_IDLE;
      kind_q  <= fqss_pkg::REQ_PUSH;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.out_dsel = fqss_pkg::DSEL_ZERO;
    cmd_o.out_stat = fqss_pkg::STAT_OK;

    case (state_q)
      fqss_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          kind_d       = req_type_i;
          case (req_type_i)
            fqss_pkg::REQ_PUSH:   state_d = fqss_pkg::S_PUSH;
            fqss_pkg::REQ_POP,
            fqss_pkg::REQ_PEEK:   state_d = fqss_pkg::S_FRONT;
            fqss_pkg::REQ_SEARCH: state_d = fqss_pkg::S_SEARCH;
            fqss_pkg::REQ_SORT:   state_d = fqss_pkg::S_SORT_PASS;
            default:              state_d = fqss_pkg::S_SIMPLE;
          endcase
        end
      end

      fqss_pkg::S_PUSH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.full) begin
            cmd_o.out_stat = fqss_pkg::STAT_FULL;
          end else begin
            cmd_o.push_wr = 1'b1;
          end
          state_d = fqss_pkg::S_IDLE;
        end
      end

      fqss_pkg::S_FRONT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.empty) begin
            cmd_o.out_stat = fqss_pkg::STAT_EMPTY;
          end else begin
            cmd_o.out_dsel = fqss_pkg::DSEL_RDATA;
            cmd_o.pop      = (kind_q == fqss_pkg::REQ_POP);
          end
          state_d = fqss_pkg::S_IDLE;
        end
      end

      fqss_pkg::S_SIMPLE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear    = (kind_q == fqss_pkg::REQ_CLEAR);
          state_d        = fqss_pkg::S_IDLE;
        end
      end

      fqss_pkg::S_SEARCH: begin
        if (sts_i.idx_end) begin
          state_d = fqss_pkg::S_SRCH_DONE;
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d      = fqss_pkg::S_SRCH_CMP;
        end
      end

      fqss_pkg::S_SRCH_CMP: begin
        if (sts_i.match) begin
          cmd_o.srch_hit = 1'b1;
          state_d        = fqss_pkg::S_SRCH_DONE;
        end else begin
          cmd_o.srch_next = 1'b1;
          state_d         = fqss_pkg::S_SEARCH;
        end
      end

      fqss_pkg::S_SRCH_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (sts_i.empty) begin
            cmd_o.out_dsel = fqss_pkg::DSEL_ONES;
            cmd_o.out_stat = fqss_pkg::STAT_EMPTY;
          end else if (sts_i.hit) begin
            cmd_o.out_dsel = fqss_pkg::DSEL_KEY;
          end else begin
            cmd_o.out_dsel = fqss_pkg::DSEL_ONES;
            cmd_o.out_stat = fqss_pkg::STAT_MISS;
          end
          state_d = fqss_pkg::S_IDLE;
        end
      end

      fqss_pkg::S_SORT_PASS: begin
        if (sts_i.sort_done) begin
          state_d = fqss_pkg::S_SIMPLE;
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d      = fqss_pkg::S_SORT_LOAD;
        end
      end

      fqss_pkg::S_SORT_LOAD: begin
        cmd_o.sort_load = 1'b1;
        state_d         = fqss_pkg::S_SORT_READ;
      end

      fqss_pkg::S_SORT_READ: begin
        if (sts_i.idx_end) begin
          cmd_o.sort_flush = 1'b1;
          state_d          = fqss_pkg::S_SORT_PASS;
        end else begin
          cmd_o.rd_idx = 1'b1;
          state_d      = fqss_pkg::S_SORT_STEP;
        end
      end

      fqss_pkg::S_SORT_STEP: begin
        cmd_o.sort_step = 1'b1;
        state_d         = fqss_pkg::S_SORT_READ;
      end

      default: begin
        state_d = fqss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fqss_dp.sv =====
// ============================================================================
// fqss_dp
// Queue datapath: ring store, pointers, walk counters and result register.
// ============================================================================
module fqss_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fqss_pkg::cmd_t                     cmd_i,
  output fqss_pkg::sts_t                     sts_o,
  input  logic signed [fqss_pkg::DW-1:0]     value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [fqss_pkg::DW-1:0]     data_o,
  output logic        [1:0]                  status_o,
  output logic        [fqss_pkg::CW-1:0]     count_o
);

  logic [fqss_pkg::AW-1:0] head_q, head_d;
  logic [fqss_pkg::CW-1:0] count_q, count_d;
  logic [fqss_pkg::CW-1:0] idx_q, idx_d;
  logic [fqss_pkg::CW-1:0] pass_q, pass_d;
  logic                    hit_q, hit_d;
  logic                    out_valid_q, out_valid_d;
  logic [fqss_pkg::DW-1:0] key_q, carry_q, out_data_q;
  logic [1:0]              out_stat_q;
  logic [fqss_pkg::CW-1:0] out_count_q;

  logic                    we;
  logic [fqss_pkg::AW-1:0] waddr, raddr;
  logic [fqss_pkg::DW-1:0] wdata, rdata;
  logic [fqss_pkg::CW-1:0] idx_prev;
  logic                    greater;

  fqss_ram #(
    .WIDTH (fqss_pkg::DW),
    .DEPTH (fqss_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign idx_prev = idx_q - fqss_pkg::CW'(1);
  assign greater  = $signed(carry_q) > $signed(rdata);
  assign raddr    = cmd_i.rd_idx ? head_q + idx_q[fqss_pkg::AW-1:0] : head_q;

  always_comb begin
    we    = 1'b0;
    waddr = head_q + idx_prev[fqss_pkg::AW-1:0];
    wdata = carry_q;
    if (cmd_i.push_wr) begin
      we    = 1'b1;
      waddr = head_q + count_q[fqss_pkg::AW-1:0];
      wdata = key_q;
    end else if (cmd_i.sort_step) begin
      we    = 1'b1;
      wdata = greater ? rdata : carry_q;
    end else if (cmd_i.sort_flush) begin
      we    = 1'b1;
    end
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    pass_d  = pass_q;
    hit_d   = hit_q;
    if (cmd_i.push_wr) begin
      count_d = count_q + fqss_pkg::CW'(1);
    end
    if (cmd_i.pop) begin
      count_d = count_q - fqss_pkg::CW'(1);
      head_d  = head_q + fqss_pkg::AW'(1);
    end
    if (cmd_i.clear) begin
      count_d = '0;
      head_d  = '0;
    end
    if (cmd_i.accept) begin
      idx_d  = '0;
      pass_d = '0;
      hit_d  = 1'b0;
    end
    if (cmd_i.srch_next || cmd_i.sort_step) begin
      idx_d = idx_q + fqss_pkg::CW'(1);
    end
    if (cmd_i.srch_hit) begin
      hit_d = 1'b1;
    end
    if (cmd_i.sort_load) begin
      idx_d = fqss_pkg::CW'(1);
    end
    if (cmd_i.sort_flush) begin
      idx_d  = '0;
      pass_d = pass_q + fqss_pkg::CW'(1);
    end
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      idx_q       <= '0;
      pass_q      <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      pass_q      <= pass_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q <= value_i;
    end
    if (cmd_i.sort_load || (cmd_i.sort_step && !greater)) begin
      carry_q <= rdata;
    end
    if (cmd_i.out_load) begin
      case (cmd_i.out_dsel)
        fqss_pkg::DSEL_RDATA: out_data_q <= rdata;
        fqss_pkg::DSEL_KEY:   out_data_q <= key_q;
        fqss_pkg::DSEL_ONES:  out_data_q <= '1;
        default:              out_data_q <= '0;
      endcase
      out_stat_q  <= cmd_i.out_stat;
      out_count_q <= count_d;
    end
  end

  assign sts_o.full      = (count_q == fqss_pkg::CW'(fqss_pkg::DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.idx_end   = (idx_q == count_q);
  assign sts_o.sort_done = ((pass_q + fqss_pkg::CW'(1)) >= count_q);
  assign sts_o.match     = (rdata == key_q);
  assign sts_o.hit       = hit_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign data_o      = $signed(out_data_q);
  assign status_o    = out_stat_q;
  assign count_o     = out_count_q;

endmodule

// ===== rtl/fifo_queue_sort_search.sv =====
// ============================================================================
// fifo_queue_sort_search
// Bounded FIFO of signed 32-bit values with search and in-place sort.
// ============================================================================
// Usage: each request transfer on the input channel (req_type_i, value_i)
// produces exactly one result transfer on the output channel (data_o,
// status_o, count_o), in request order. Requests are push, pop, peek at the
// oldest entry, search for a key, sort the held entries ascending, and clear.
// The block works on one request at a time. Push, pop, peek, clear and the
// unused request codes are taken in the idle state and then, in a second
// state, update the queue and load the result register. A search walks the
// held entries through the single read port of the ring store, with a read
// state and a compare state per entry. A sort runs n-1 bubble passes over n
// entries, each pass again a walk of the store through its single read port.
// The result sits in an output register; the next request is taken while it
// waits, and only the final step of that next request waits for the
// receiver. After reset the queue is empty with the head at position zero;
// the store contents are not cleared and need no clearing pass.
// ============================================================================
module fifo_queue_sort_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [2:0]                     req_type_i,
  input  logic signed [fqss_pkg::DW-1:0] value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [fqss_pkg::DW-1:0] data_o,
  output logic [1:0]                     status_o,
  output logic [fqss_pkg::CW-1:0]        count_o
);

  // Command and status groups between the sequencer and the datapath.
  fqss_pkg::cmd_t cmd;
  fqss_pkg::sts_t sts;

  // The sequencer decodes a request at its transfer and steps through it.
  fqss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the ring store, head and fill count, the walk
  // counters for search and sort, and the output register.
  fqss_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

endmodule

// ===== verif/queue_result_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// queue_result_checker
// Watches both channels of the queue, predicts every result and compares.
// ============================================================================
// Each request transfer is run through a private copy of the queue, which
// holds its own ring store, head position and fill count. The predicted reply
// is held until the matching result transfer arrives, and then the data,
// status and count fields are checked one at a time.
// ============================================================================
module queue_result_checker
  import fqss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [2:0]            req_type_i,
  input  logic signed [DW-1:0]  value_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic signed [DW-1:0]  data_i,
  input  logic [1:0]            status_i,
  input  logic [CW-1:0]         count_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           replies_due_o
);

  typedef struct packed {
    logic signed [DW-1:0] data;
    logic [1:0]           status;
    logic [CW-1:0]        count;
  } reply_t;

  logic signed [DW-1:0] model_store [DEPTH];
  int unsigned          model_head;
  int unsigned          model_fill;
  reply_t               replies_due [$];

  function automatic reply_t apply_queue_request(input logic [2:0] kind,
                                                 input logic signed [DW-1:0] key);
    reply_t               reply;
    logic signed [DW-1:0] swap_word;
    int unsigned          sweep;
    int unsigned          pos;
    int unsigned          slot_a;
    int unsigned          slot_b;
    bit                   found;
    reply.data   = '0;
    reply.status = STAT_OK;
    found        = 1'b0;
    case (kind)
      REQ_PUSH: begin
        if (model_fill >= DEPTH) begin
          reply.status = STAT_FULL;
        end else begin
          model_store[(model_head + model_fill) % DEPTH] = key;
          model_fill++;
        end
      end
      REQ_POP: begin
        if (model_fill == 0) begin
          reply.status = STAT_EMPTY;
        end else begin
          reply.data = model_store[model_head];
          model_head = (model_head + 1) % DEPTH;
          model_fill--;
        end
      end
      REQ_PEEK: begin
        if (model_fill == 0) reply.status = STAT_EMPTY;
        else reply.data = model_store[model_head];
      end
      REQ_SEARCH: begin
        if (model_fill == 0) begin
          reply.data   = '1;
          reply.status = STAT_EMPTY;
        end else begin
          for (pos = 0; pos < model_fill; pos++) begin
            if (model_store[(model_head + pos) % DEPTH] == key) found = 1'b1;
          end
          if (found) begin
            reply.data = key;
          end else begin
            reply.data   = '1;
            reply.status = STAT_MISS;
          end
        end
      end
      REQ_SORT: begin
        // Bubble passes in queue order; the store words compare as signed.
        for (sweep = 0; sweep < model_fill; sweep++) begin
          for (pos = 0; pos + 1 < model_fill; pos++) begin
            slot_a = (model_head + pos) % DEPTH;
            slot_b = (model_head + pos + 1) % DEPTH;
            if (model_store[slot_a] > model_store[slot_b]) begin
              swap_word           = model_store[slot_a];
              model_store[slot_a] = model_store[slot_b];
              model_store[slot_b] = swap_word;
            end
          end
        end
      end
      REQ_CLEAR: begin
        model_fill = 0;
        model_head = 0;
      end
      default: begin
      end
    endcase
    reply.count = CW'(model_fill);
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      model_head       = 0;
      model_fill       = 0;
      mismatch_count_o = 0;
      replies_due.delete();
      replies_due_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        replies_due.push_back(apply_queue_request(req_type_i, value_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with no request waiting: data %0d status %0d count %0d",
                   $time, data_i, status_i, count_i);
          mismatch_count_o++;
        end else begin
          want = replies_due.pop_front();
          if (data_i !== want.data) begin
            $display("%0t: data expected %0d, actual %0d", $time, want.data, data_i);
            mismatch_count_o++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, status_i);
            mismatch_count_o++;
          end
          if (count_i !== want.count) begin
            $display("%0t: count expected %0d, actual %0d", $time, want.count, count_i);
            mismatch_count_o++;
          end
        end
      end
      replies_due_o = replies_due.size();
    end
  end

endmodule

// ===== verif/tb_fifo_queue_sort_search.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_fifo_queue_sort_search
// Testbench of the bounded FIFO queue with search and in-place sort.
// ============================================================================
// A short directed sequence covers the empty-queue cases, the unused request
// codes, signed extremes, a search hit and miss and a sort. Random traffic
// follows in segments that steer the fill level, either kept low or driven
// into the full condition, with idle gaps on the request side and stalls on
// the result side. The checker beside the block predicts and compares.
// ============================================================================
module tb_fifo_queue_sort_search;
  import fqss_pkg::*;

  // Request codes outside the package enum; the block treats them as no-ops.
  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  localparam int unsigned RANDOM_REQUESTS = 1300;
  localparam int unsigned SETTLE_CYCLES   = 50;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [2:0]           req_type_i;
  logic signed [DW-1:0] value_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic signed [DW-1:0] data_o;
  logic [1:0]           status_o;
  logic [CW-1:0]        count_o;

  int unsigned mismatch_count;
  int unsigned replies_due;

  // Shaping state for the stimulus only: a running fill estimate, whether the
  // current segment runs without idle gaps, and a few recently pushed values
  // so that searches hit as well as miss.
  int unsigned          fill_guess;
  bit                   no_idle;
  logic signed [DW-1:0] recent_pushes [16];
  int unsigned          recent_wr;

  fifo_queue_sort_search uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (data_o),
    .status_o    (status_o),
    .count_o     (count_o)
  );

  queue_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .req_type_i       (req_type_i),
    .value_i          (value_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .data_i           (data_o),
    .status_i         (status_o),
    .count_i          (count_o),
    .mismatch_count_o (mismatch_count),
    .replies_due_o    (replies_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Idle gap length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_cycles();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Values lean toward a small pool so duplicates and sort ties are common,
  // with the signed extremes and fully random words mixed in.
  function automatic logic signed [DW-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return DW'($signed($urandom_range(0, 16)) - 8);
    if (roll < 60) begin
      case ($urandom_range(0, 4))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // One request transfer. The valid stays high through to the next request
  // when no gap follows, so it is never lowered and raised in one step.
  task automatic issue_request(input logic [2:0] kind, input logic signed [DW-1:0] word);
    int unsigned gap;
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    value_i    <= word;
    do @(posedge clk_i); while (!in_ready_o);
    case (kind)
      REQ_PUSH: begin
        if (fill_guess < DEPTH) fill_guess++;
        recent_pushes[recent_wr] = word;
        recent_wr = (recent_wr + 1) % 16;
      end
      REQ_POP:   if (fill_guess > 0) fill_guess--;
      REQ_CLEAR: fill_guess = 0;
      default: begin
      end
    endcase
    gap = no_idle ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds off new requests until every outstanding result has been taken.
  // The count is looked at on the falling edge, once the checker has seen
  // the last transfer, and driving resumes on a rising edge.
  task automatic settle_queue();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (replies_due != 0);
    @(posedge clk_i);
  endtask

  // Result side: ready runs high or low for random stretches, including long
  // stretches with no stall at all.
  initial begin
    int unsigned hold;
    int unsigned roll;
    bit          level;
    hold        = 0;
    level       = 1'b0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold == 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 45) begin
          level = 1'b1;
          hold  = $urandom_range(1, 8);
        end else if (roll < 55) begin
          level = 1'b1;
          hold  = $urandom_range(60, 200);
        end else if (roll < 85) begin
          level = 1'b0;
          hold  = $urandom_range(1, 3);
        end else if (roll < 97) begin
          level = 1'b0;
          hold  = $urandom_range(4, 10);
        end else begin
          level = 1'b0;
          hold  = $urandom_range(20, 50);
        end
      end
      out_ready_i <= level;
      hold--;
      @(posedge clk_i);
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned sent_random;
    int unsigned segment;
    int unsigned seg_len;
    int unsigned target;
    int unsigned step;
    int unsigned roll;
    bit          fill_up;
    logic signed [DW-1:0] key;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    req_type_i  <= REQ_PUSH;
    value_i     <= '0;
    fill_guess  = 0;
    no_idle     = 1'b0;
    recent_wr   = 0;
    sent_random = 0;
    segment     = 0;
    foreach (recent_pushes[i]) recent_pushes[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every request but push on an empty queue, then the two unused codes.
    issue_request(REQ_POP,    32'sd0);
    issue_request(REQ_PEEK,   32'sd0);
    issue_request(REQ_SEARCH, 32'sd0);
    issue_request(REQ_SORT,   32'sd0);
    issue_request(REQ_CLEAR,  32'sd0);
    issue_request(REQ_UNUSED_LO, 32'sh7FFF_FFFF);
    issue_request(REQ_UNUSED_HI, 32'sh8000_0000);
    // Signed extremes out of order, so the sort has to move the most
    // negative word to the front.
    issue_request(REQ_PUSH, 32'sh7FFF_FFFF);
    issue_request(REQ_PUSH, 32'sh8000_0000);
    issue_request(REQ_PUSH, 32'sd0);
    issue_request(REQ_PUSH, -32'sd1);
    issue_request(REQ_PUSH, 32'sd1);
    issue_request(REQ_PEEK, 32'sd0);
    issue_request(REQ_SEARCH, -32'sd1);
    issue_request(REQ_SEARCH, 32'sd5);
    issue_request(REQ_SORT, 32'sd0);
    issue_request(REQ_PEEK, 32'sd0);
    issue_request(REQ_POP,  32'sd0);
    issue_request(REQ_POP,  32'sd0);
    issue_request(REQ_SEARCH, 32'sh7FFF_FFFF);
    issue_request(REQ_CLEAR, 32'sd0);
    issue_request(REQ_POP,  32'sd0);
    settle_queue();

    // Random segments. The first one, and about one in six after it, pushes
    // the queue past full so dropped pushes and sorts of a full ring occur;
    // the rest keep the fill low, where sorts and searches stay cheap.
    while (sent_random < RANDOM_REQUESTS) begin
      segment++;
      fill_up = (segment == 1) || ($urandom_range(0, 5) == 0);
      target  = fill_up ? DEPTH + 3 : $urandom_range(0, 12);
      seg_len = fill_up ? $urandom_range(180, 220) : $urandom_range(20, 60);
      no_idle = ($urandom_range(0, 4) == 0);
      for (step = 0; step < seg_len; step++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
          issue_request($urandom_range(0, 1) ? REQ_UNUSED_HI : REQ_UNUSED_LO, $urandom);
        end else begin
          if (roll < 5) begin
            issue_request(REQ_SORT, $urandom);
          end else if (roll < 7 && !fill_up) begin
            issue_request(REQ_CLEAR, $urandom);
          end else if (roll < 19) begin
            key = ($urandom_range(0, 2) != 0) ? recent_pushes[$urandom_range(0, 15)]
                                              : pick_value();
            issue_request(REQ_SEARCH, key);
          end else if (roll < 27) begin
            issue_request(REQ_PEEK, $urandom);
          end else if ((fill_guess < target) == ($urandom_range(0, 99) < (fill_up ? 85 : 70)))
          begin
            issue_request(REQ_PUSH, pick_value());
          end else begin
            issue_request(REQ_POP, $urandom);
          end
          sent_random++;
        end
      end
      if (segment % 5 == 0) settle_queue();
    end

    settle_queue();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && replies_due == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest run the stimulus can produce.
  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fqss_pkg.sv
rtl/fqss_ram.sv
rtl/fqss_ctrl.sv
rtl/fqss_dp.sv
rtl/fifo_queue_sort_search.sv
verif/queue_result_checker.sv
verif/tb_fifo_queue_sort_search.sv
